@@ design/keypad_number_table_average_macros.svh @@
// Assertion macros used by the checker file of the keypad number table block.
`ifndef KEYPAD_NUMBER_TABLE_AVERAGE_MACROS_SVH
`define KEYPAD_NUMBER_TABLE_AVERAGE_MACROS_SVH

// Checks that the consequent holds in the cycle after the antecedent.
`define KNT_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("keypad table: next-cycle check failed");

// Checks that the consequent holds in the same cycle as the antecedent.
`define KNT_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("keypad table: same-cycle check failed");

`endif

@@ design/kntavg_pkg.sv @@
// Shared types and constants of the keypad number table average block.
package kntavg_pkg;

    localparam int VAL_W      = 54;
    localparam int SUM_W      = 64;
    localparam int KEY_W      = 8;
    localparam int SLOT_OUT_W = 4;
    localparam int CNT_OUT_W  = 5;
    localparam int DIV_STEPS  = 64;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [KEY_W-1:0] KEY_MAX = 8'd9;

    localparam logic REQ_DIGIT = 1'b0;
    localparam logic REQ_ENTER = 1'b1;

    // Result word layout, lowest bit first.
    localparam int OUT_VAL_LSB  = 0;
    localparam int OUT_SLOT_LSB = OUT_VAL_LSB + VAL_W;
    localparam int OUT_AVG_LSB  = OUT_SLOT_LSB + SLOT_OUT_W;
    localparam int OUT_CNT_LSB  = OUT_AVG_LSB + VAL_W;
    localparam int OUT_USED_W   = OUT_CNT_LSB + CNT_OUT_W;
    localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SUB,
        B_ADD,
        B_DIV,
        B_DONE
    } back_state_t;

    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] value;
    } entry_push_t;

    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] value;
    } queue_head_t;

endpackage

@@ design/kntavg_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module kntavg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/kntavg_queue.sv @@
// Two-entry queue that carries finished numbers from the front to the back.
module kntavg_queue
    import kntavg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  entry_push_t push,
    input  logic        pop,
    output queue_head_t head,
    output logic        full
);

    logic [VAL_W-1:0]  mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;
    logic [QCNT_W-1:0] fill_next;

    always_comb
    begin
        fill_next = fill_reg;
        if (push.valid && !pop)
        begin
            fill_next = fill_reg + QCNT_W'(1);
        end
        else if (!push.valid && pop)
        begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.value;
        end
    end

    assign head.valid = (fill_reg != '0);
    assign head.value = mem_reg[rd_ptr_reg];
    assign full       = (fill_reg == QCNT_W'(QDEPTH));

endmodule

@@ design/kntavg_front.sv @@
// Front end: accepts key transactions and builds the decimal number under entry.
module kntavg_front
    import kntavg_pkg::*;
#(
    parameter int DIGIT_DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [KEY_W-1:0] s_tdata,
    input  logic [0:0]       s_tuser,
    input  logic             q_full,
    output entry_push_t      push
);

    localparam int DW = $clog2(DIGIT_DEPTH + 1);

    logic [VAL_W-1:0] entry_value_reg;
    logic [VAL_W-1:0] entry_value_next;
    logic [DW-1:0]    entry_digits_reg;
    logic [DW-1:0]    entry_digits_next;
    logic             accept;
    logic [VAL_W-1:0] times_ten;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign times_ten = (entry_value_reg << 3) + (entry_value_reg << 1);

    always_comb
    begin
        entry_value_next  = entry_value_reg;
        entry_digits_next = entry_digits_reg;
        push.valid        = 1'b0;
        push.value        = entry_value_reg;
        if (accept)
        begin
            if (s_tuser[0] == REQ_ENTER)
            begin
                push.valid        = 1'b1;
                entry_value_next  = '0;
                entry_digits_next = '0;
            end
            else if (s_tdata <= KEY_MAX && entry_digits_reg < DW'(DIGIT_DEPTH))
            begin
                // The product wraps to the value width.
                entry_value_next  = times_ten + {{(VAL_W-KEY_W){1'b0}}, s_tdata};
                entry_digits_next = entry_digits_reg + DW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_value_reg  <= '0;
            entry_digits_reg <= '0;
        end
        else
        begin
            entry_value_reg  <= entry_value_next;
            entry_digits_reg <= entry_digits_next;
        end
    end

endmodule

@@ design/kntavg_back.sv @@
// Back end: updates the ring table and running sum, divides, and holds the result.
module kntavg_back
    import kntavg_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  queue_head_t           head,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    back_state_t state_reg;
    back_state_t state_next;

    logic [VAL_W-1:0]  val_reg;
    logic [VAL_W-1:0]  val_next;
    logic [SW-1:0]     slot_reg;
    logic [SW-1:0]     slot_next;
    logic [SW-1:0]     out_slot_reg;
    logic [SW-1:0]     out_slot_next;
    logic              wrapped_reg;
    logic              wrapped_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [SUM_W-1:0]  dq_reg;
    logic [SUM_W-1:0]  dq_next;
    logic [CW-1:0]     rem_reg;
    logic [CW-1:0]     rem_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic              ram_we;
    logic              ram_re;
    logic              load_out;
    logic              out_free;
    logic [VAL_W-1:0]  ram_rdata;
    logic [VAL_W-1:0]  old_val;
    logic [CW:0]       rem_shift;
    logic [CW:0]       rem_diff;
    logic              q_bit;
    logic [VAL_W-1:0]  avg;
    logic [SW+SLOT_OUT_W-1:0] slot_ext;
    logic [CW+CNT_OUT_W-1:0]  cnt_ext;

    kntavg_ram #(
        .WIDTH(VAL_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(slot_reg),
        .wdata(val_reg),
        .re   (ram_re),
        .raddr(slot_reg),
        .rdata(ram_rdata)
    );

    assign out_free = !out_valid_reg || m_tready;

    // Slots are written in ring order, so the slot about to be written holds data only once the ring has wrapped.
    assign old_val = wrapped_reg ? ram_rdata : '0;

    assign rem_shift = {rem_reg, dq_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, count_reg};
    assign q_bit     = (rem_shift >= {1'b0, count_reg});

    assign avg      = (count_reg == '0) ? '0 : dq_reg[VAL_W-1:0];
    assign slot_ext = {{SLOT_OUT_W{1'b0}}, out_slot_reg};
    assign cnt_ext  = {{CNT_OUT_W{1'b0}}, count_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = B_SUB;
                end
            end
            B_SUB:
            begin
                state_next = B_ADD;
            end
            B_ADD:
            begin
                state_next = B_DIV;
            end
            B_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        ram_re   = 1'b0;
        ram_we   = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                pop    = head.valid;
                ram_re = head.valid;
            end
            B_SUB:
            begin
                ram_we = 1'b1;
            end
            B_ADD:
            begin
            end
            B_DIV:
            begin
            end
            B_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        val_next       = val_reg;
        slot_next      = slot_reg;
        out_slot_next  = out_slot_reg;
        wrapped_next   = wrapped_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_IDLE:
            begin
                if (head.valid)
                begin
                    val_next = head.value;
                end
            end
            B_SUB:
            begin
                if (old_val != '0)
                begin
                    sum_next   = sum_reg - {{(SUM_W-VAL_W){1'b0}}, old_val};
                    count_next = count_reg - CW'(1);
                end
            end
            B_ADD:
            begin
                if (val_reg != '0)
                begin
                    sum_next   = sum_reg + {{(SUM_W-VAL_W){1'b0}}, val_reg};
                    count_next = count_reg + CW'(1);
                end
                dq_next       = sum_next;
                rem_next      = '0;
                step_next     = '0;
                out_slot_next = slot_reg;
                if (slot_reg == SW'(TABLE_DEPTH - 1))
                begin
                    slot_next    = '0;
                    wrapped_next = 1'b1;
                end
                else
                begin
                    slot_next = slot_reg + SW'(1);
                end
            end
            B_DIV:
            begin
                // One restoring step: the quotient bit shifts in where the dividend leaves.
                dq_next   = {dq_reg[SUM_W-2:0], q_bit};
                rem_next  = q_bit ? rem_diff[CW-1:0] : rem_shift[CW-1:0];
                step_next = step_reg + STEP_W'(1);
            end
            B_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next[OUT_VAL_LSB +: VAL_W]       = val_reg;
                    out_data_next[OUT_SLOT_LSB +: SLOT_OUT_W] = slot_ext[SLOT_OUT_W-1:0];
                    out_data_next[OUT_AVG_LSB +: VAL_W]       = avg;
                    out_data_next[OUT_CNT_LSB +: CNT_OUT_W]   = cnt_ext[CNT_OUT_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            slot_reg      <= '0;
            wrapped_reg   <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            wrapped_reg   <= wrapped_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        out_slot_reg <= out_slot_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ design/keypad_number_table_average.sv @@
// Top level of the keypad number entry block with ring table and running average.
//
// Slave stream: one key event per transaction. s_tuser carries the request type
// (0 digit, 1 enter) and s_tdata the 8-bit key code. Digits 0 to 9 extend the
// number under entry; other codes, and digits past DIGIT_DEPTH, are dropped.
// Master stream: one transaction per enter event carrying the stored number,
// its slot, the floor mean of the nonzero table entries and their count.
// Digit transactions produce no output and are taken in one cycle each while
// the queue is not full. An enter result passes through the queue, the back
// end's SUB, ADD, DIV and DONE states and the output register. The restoring
// 64-step divider takes one number at a time while up to two more wait in the queue.
// Digits keep flowing while the back end works, until the queue is full.
// A result waits in the output register while m_tready is low; the back end
// then holds its next result and the queue fills before s_tready drops.
// Reset clears the entry, the running sum and count, the slot pointer and the
// queue; the table reads as zero until each slot is written once, so no
// clearing pass is needed and the block is ready in the first cycle.
module keypad_number_table_average
    import kntavg_pkg::*;
#(
    parameter int DIGIT_DEPTH = 16,
    parameter int TABLE_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [KEY_W-1:0]      s_tdata,  // key_value
    input  logic [0:0]            s_tuser,  // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // stored_value, stored_slot, average, nonzero_entries, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata
);

    entry_push_t push;
    queue_head_t head;
    logic        q_full;
    logic        pop;

    kntavg_front #(
        .DIGIT_DEPTH(DIGIT_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .q_full  (q_full),
        .push    (push)
    );

    kntavg_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .pop  (pop),
        .head (head),
        .full (q_full)
    );

    kntavg_back #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule

@@ design/kntavg_checker.sv @@
// Port-level checker for the keypad number table block and its bind statement.
`include "keypad_number_table_average_macros.svh"

module kntavg_checker
    import kntavg_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    logic [VAL_W-1:0]     out_value;
    logic [VAL_W-1:0]     out_avg;
    logic [CNT_OUT_W-1:0] out_cnt;

    assign out_value = m_tdata[OUT_VAL_LSB +: VAL_W];
    assign out_avg   = m_tdata[OUT_AVG_LSB +: VAL_W];
    assign out_cnt   = m_tdata[OUT_CNT_LSB +: CNT_OUT_W];

    `KNT_ASSERT_NEXT(a_stall_valid, m_tvalid && !m_tready, m_tvalid)
    `KNT_ASSERT_NEXT(a_stall_data, m_tvalid && !m_tready, $stable(m_tdata))
    // With no nonzero entries the mean must be zero; the count field is exact below 32.
    `KNT_ASSERT_NOW(a_empty_mean, (TABLE_DEPTH < 32) && m_tvalid && out_cnt == '0, out_avg == '0)
    // A nonzero stored number is itself a nonzero table entry.
    `KNT_ASSERT_NOW(a_value_counted, (TABLE_DEPTH < 32) && m_tvalid && out_value != '0,
        out_cnt != '0)

endmodule

bind keypad_number_table_average kntavg_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
) u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

@@ dv/tb_keypad_number_table_average.sv @@
// Self-checking testbench of the keypad number table average block.
`timescale 1ns / 1ps

module tb_keypad_number_table_average;
    import kntavg_pkg::*;

    localparam int DIGIT_DEPTH = 16;
    localparam int TABLE_DEPTH = 16;
    localparam int ITEM_TARGET = 1450;
    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        logic [VAL_W-1:0]      value;
        logic [SLOT_OUT_W-1:0] slot;
        logic [VAL_W-1:0]      avg;
        logic [CNT_OUT_W-1:0]  cnt;
    } table_result_t;

    typedef struct {
        logic          req;
        logic [7:0]    key;
        bit            typed;
        table_result_t res;
    } key_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [KEY_W-1:0]      s_tdata;   // key_value
    logic [0:0]            s_tuser;   // req_type
    logic                  m_tvalid;
    logic                  m_tready;
    // stored_value, stored_slot, average, nonzero_entries, zero fill
    logic [OUT_DATA_W-1:0] m_tdata;

    // Predictor state: the number being typed and the ring of stored numbers.
    bit [VAL_W-1:0] typed_number;
    int             typed_digits;
    bit [VAL_W-1:0] ring [TABLE_DEPTH];
    int             ring_slot;
    bit [SUM_W-1:0] ring_sum;
    int             ring_nonzero;

    table_result_t pending_table_results[$];
    key_row_t      key_rows[$];
    int            error_count;
    int            results_seen;
    int            sent_items;
    bit            sender_quiet;
    bit            hold_done;

    keypad_number_table_average #(
        .DIGIT_DEPTH(DIGIT_DEPTH),
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Updates the typed number or the ring model for one key event and works out the table result.
    task automatic predict_table_result(input logic req, input logic [7:0] key,
                                        output bit produced, output table_result_t res);
        bit [VAL_W-1:0] old_v;
        bit [VAL_W-1:0] new_v;
        int             s;
        produced  = 1'b0;
        res       = '0;
        if (req == REQ_DIGIT)
        begin
            if (key <= KEY_MAX && typed_digits < DIGIT_DEPTH)
            begin
                typed_number = typed_number * 10 + key;
                typed_digits++;
            end
        end
        else
        begin
            s     = ring_slot;
            new_v = typed_number;
            old_v = ring[s];
            if (old_v != 0)
            begin
                ring_sum -= old_v;
                ring_nonzero--;
            end
            if (new_v != 0)
            begin
                ring_sum += new_v;
                ring_nonzero++;
            end
            ring[s]      = new_v;
            ring_slot    = (s + 1) % TABLE_DEPTH;
            typed_number = '0;
            typed_digits = 0;
            res.value    = new_v;
            res.slot     = s[SLOT_OUT_W-1:0];
            res.avg      = (ring_nonzero == 0) ? '0 : VAL_W'(ring_sum / SUM_W'(ring_nonzero));
            res.cnt      = ring_nonzero[CNT_OUT_W-1:0];
            produced     = 1'b1;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic req, input logic [7:0] key,
                             input bit typed, input table_result_t typed_res);
        bit            produced;
        table_result_t res;
        while (!sender_quiet && $urandom_range(0, 99) < 9)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= key;
        do
            @(posedge clk);
        while (!s_tready);
        predict_table_result(req, key, produced, res);
        if (produced)
            pending_table_results.push_back(typed ? typed_res : res);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic add_row(input logic req, input logic [7:0] key, input bit typed,
                           input table_result_t res);
        key_row_t row;
        row.req   = req;
        row.key   = key;
        row.typed = typed;
        row.res   = res;
        key_rows.push_back(row);
    endtask

    // Stimulus: directed rows first, then random numbers typed and entered.
    initial
    begin
        table_result_t none;
        table_result_t r;
        int            n;
        bit            zero_number;
        bit            paused;
        none         = '0;
        paused       = 1'b0;
        sender_quiet = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        typed_number = '0;
        typed_digits = 0;
        ring_slot    = 0;
        ring_sum     = '0;
        ring_nonzero = 0;
        for (int k = 0; k < TABLE_DEPTH; k++)
            ring[k] = '0;

        // Enter right after reset stores zero and the mean is zero.
        add_row(REQ_ENTER, 8'd0, 1'b1, none);
        // Sixteen nines fill the entry; the next nine and keys above nine are dropped.
        for (int k = 0; k < DIGIT_DEPTH; k++)
            add_row(REQ_DIGIT, 8'd9, 1'b0, none);
        add_row(REQ_DIGIT, 8'd9, 1'b0, none);
        add_row(REQ_DIGIT, 8'd10, 1'b0, none);
        add_row(REQ_DIGIT, 8'd255, 1'b0, none);
        r.value = 54'd9999999999999999;
        r.slot  = 4'd1;
        r.avg   = 54'd9999999999999999;
        r.cnt   = 5'd1;
        add_row(REQ_ENTER, 8'd255, 1'b1, r);
        add_row(REQ_DIGIT, 8'd0, 1'b0, none);
        add_row(REQ_DIGIT, 8'd7, 1'b0, none);
        add_row(REQ_ENTER, 8'd128, 1'b0, none);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (key_rows[i])
            send_item(key_rows[i].req, key_rows[i].key, key_rows[i].typed, key_rows[i].res);

        while (sent_items < ITEM_TARGET)
        begin
            sender_quiet = (sent_items >= 400 && sent_items < 600);
            if (!paused && sent_items >= 900)
            begin
                // Let the block drain completely before going on.
                s_tvalid <= 1'b0;
                do
                    @(negedge clk);
                while (pending_table_results.size() != 0);
                paused = 1'b1;
            end
            n = $urandom_range(0, 99);
            if (n < 80)
            begin
                n           = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 18)
                                                         : $urandom_range(0, 8);
                zero_number = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(REQ_DIGIT, 8'($urandom_range(10, 255)), 1'b0, none);
                    send_item(REQ_DIGIT, zero_number ? 8'd0 : 8'($urandom_range(0, 9)),
                              1'b0, none);
                end
                send_item(REQ_ENTER, 8'($urandom_range(0, 255)), 1'b0, none);
            end
            else if (n < 90)
            begin
                repeat ($urandom_range(1, 4))
                    send_item(REQ_DIGIT, 8'($urandom_range(0, 255)), 1'b0, none);
            end
            else
                send_item(REQ_ENTER, 8'($urandom_range(0, 255)), 1'b0, none);
        end
        s_tvalid <= 1'b0;

        while (pending_table_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0 && pending_table_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random back-pressure, one long hold-off, and a quiet stretch.
    initial
    begin
        m_tready  = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= 15)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            m_tready <= (results_seen >= 40 && results_seen < 70) ||
                        ($urandom_range(0, 99) >= 9);
        end
    end

    // Each result transaction is compared with the oldest expected one.
    always @(posedge clk)
    begin
        table_result_t want;
        table_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got.value = m_tdata[OUT_VAL_LSB +: VAL_W];
            got.slot  = m_tdata[OUT_SLOT_LSB +: SLOT_OUT_W];
            got.avg   = m_tdata[OUT_AVG_LSB +: VAL_W];
            got.cnt   = m_tdata[OUT_CNT_LSB +: CNT_OUT_W];
            if (pending_table_results.size() == 0)
            begin
                if (error_count < 10)
                    $display("unexpected transaction: value %0d slot %0d avg %0d cnt %0d",
                             got.value, got.slot, got.avg, got.cnt);
                error_count++;
            end
            else
            begin
                want = pending_table_results.pop_front();
                if (got.value !== want.value || got.slot !== want.slot ||
                    got.avg !== want.avg || got.cnt !== want.cnt)
                begin
                    if (error_count < 10)
                        $display("mismatch: exp value %0d slot %0d avg %0d cnt %0d, %s",
                                 want.value, want.slot, want.avg, want.cnt,
                                 $sformatf("got value %0d slot %0d avg %0d cnt %0d",
                                           got.value, got.slot, got.avg, got.cnt));
                    error_count++;
                end
            end
        end
    end

endmodule

@@ sim.f @@
+incdir+design
design/kntavg_pkg.sv
design/kntavg_ram.sv
design/kntavg_queue.sv
design/kntavg_front.sv
design/kntavg_back.sv
design/keypad_number_table_average.sv
design/kntavg_checker.sv
dv/tb_keypad_number_table_average.sv
